### rtl/sqws_pkg.sv
// Shared types and constants for the square-window zero spread block.
// No dependencies; imported by the channel interfaces and the top level.

package sqws_pkg;

    // Payload and configuration widths
    localparam int PIX_W = 8;
    localparam int CFG_W = 11;

    // Frame height limit and row counter widths
    localparam int MAX_HEIGHT = 1024;
    localparam int OROW_W     = 10;   // output row, below MAX_HEIGHT
    localparam int VROW_W     = 11;   // raster row, runs past the frame while flushing

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Input item kinds
    typedef enum logic [0:0] {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } item_kind_t;

endpackage

### rtl/sqws_pixel_if.sv
// Input channel: one mask pixel or flush tick per transfer.
// Depends on sqws_pkg.

interface sqws_pixel_if;
    import sqws_pkg::*;

    logic             valid;
    logic             ready;
    item_kind_t       kind;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output kind, output pixel_in, input ready);
    modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

### rtl/sqws_result_if.sv
// Result channel: one output pixel per transfer, last one of a frame marked.
// Depends on sqws_pkg.

interface sqws_result_if;
    import sqws_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

### rtl/sqws_cfg_if.sv
// Configuration write channel: register index and write data per transfer.
// Depends on sqws_pkg.

interface sqws_cfg_if;
    import sqws_pkg::*;

    logic             valid;
    logic             ready;
    cfg_index_t       index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/square_window_zero_spread.sv
// Square-window zero spread: erosion of non-zero mask pixels, raster in/out.
// Depends on sqws_pkg, sqws_pixel_if, sqws_result_if, sqws_cfg_if.
//
// pixels  - mask pixels of a frame in raster order (kind = pixel), then flush
//           ticks (kind = flush) that push out the last results.
// results - one pixel per item once RADIUS*width+RADIUS pixels are in;
//           frame_end marks the last pixel of the frame.
// regs    - image_width / image_height writes, always ready; a write restarts
//           the frame counters. Write only while idle.
// One item per clock while input ready is high; the item that releases a
// result passes stage one and the output queue before the result is offered.
// A frame of no more than RADIUS*width+RADIUS pixels releases nothing before
// its flush ticks: after its last pixel the block runs internal steps with
// input ready low until the lag counter reaches RADIUS*width+RADIUS.
// Per-column distance to the last zero in RAM (one read, one write per step);
// centre pixels in a circular delay RAM of RADIUS*MAX_WIDTH+RADIUS+1 entries.
// A four-entry output queue keeps input ready while a result waits; ready
// drops when the queue cannot take what is in flight, so a stalled receiver
// backs up into the input. Reset clears the counters and queue, loads 640x480.

module square_window_zero_spread #(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    sqws_pixel_if.sink    pixels,
    sqws_result_if.source results,
    sqws_cfg_if.sink      regs
);
    import sqws_pkg::*;

    localparam int WIN     = 2 * RADIUS + 1;
    localparam int HW      = 2 * RADIUS;
    localparam int DW      = $clog2(2 * RADIUS + 2);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int SW      = $clog2(MAX_WIDTH + RADIUS + 1);
    localparam int LAG_MAX = RADIUS * MAX_WIDTH + RADIUS;
    localparam int LW      = $clog2(LAG_MAX + 1);
    localparam int PD      = LAG_MAX + 1;
    localparam int PAW     = $clog2(PD);
    localparam int FD      = 4;
    localparam int FAW     = 2;
    localparam int FCW     = 3;

    localparam logic [DW-1:0] SAT = DW'(2 * RADIUS + 1);

    // Configuration registers
    logic [CFG_W-1:0] width_reg, height_reg;

    // Raster, lag and output counters
    logic [XW-1:0]     vcol_reg, vcol_next;
    logic [VROW_W-1:0] vrow_reg, vrow_next;
    logic [LW-1:0]     lead_cnt_reg, lead_cnt_next;
    logic              emit_on_reg, emit_on_next;
    logic [XW-1:0]     out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;
    logic [PAW-1:0]    wptr_reg, wptr_next;
    logic [PAW-1:0]    rptr_reg, rptr_next;

    // Stage one
    logic           s1_valid_reg, s1_emit_reg, s1_end_reg;
    logic           s1_zero_reg, s1_row0_reg, s1_fwd_reg;
    logic [XW-1:0]  s1_col_reg;
    logic [WIN-1:0] s1_mask_reg;
    logic [DW-1:0]  fwd_val_reg, dist_q_reg;
    logic [PIX_W-1:0] pix_q_reg;
    logic [HW-1:0]  hist_reg;

    // Memories
    logic [DW-1:0]    dist_mem [MAX_WIDTH];
    logic [PIX_W-1:0] pix_mem  [PD];

    // Output queue
    logic [PIX_W-1:0] fifo_pix_reg [FD];
    logic             fifo_end_reg [FD];
    logic [FAW-1:0]   wr_idx_reg, rd_idx_reg;
    logic [FCW-1:0]   cnt_reg;

    // Combinational
    logic [WW-1:0]     uw;
    logic [VROW_W-1:0] uh;
    logic [LW-1:0]     lag;
    logic              accept, is_pix, row_in_frame, step, emit_now;
    logic              flow, catchup, pix_step;
    logic              col_last, out_col_last, out_row_last, frame_done, cfg_write;
    logic [SW-1:0]     cpr;
    logic [WIN-1:0]    mask;
    logic [DW-1:0]     d_old, d_new;
    logic              vz_new, zero_hit, push, pop;
    logic [WIN-1:0]    win;

    // Saturated frame size and pipeline lag
    always_comb
    begin
        if (width_reg == '0)
            uw = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            uw = WW'(MAX_WIDTH);
        else
            uw = WW'(width_reg);

        if (height_reg == '0)
            uh = VROW_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            uh = VROW_W'(MAX_HEIGHT);
        else
            uh = VROW_W'(height_reg);

        lag = LW'(uw) * LW'(RADIUS) + LW'(RADIUS);
    end

    // Step decode: a pixel counts while rows remain, a flush once they are in;
    // a small frame steps on its own until the lag is reached
    assign accept       = pixels.valid && pixels.ready;
    assign is_pix       = (pixels.kind == KIND_PIXEL);
    assign row_in_frame = (vrow_reg < uh);
    assign catchup      = !row_in_frame && !emit_on_reg && (lead_cnt_reg != lag);
    assign flow         = accept && (is_pix ? row_in_frame : !row_in_frame);
    assign pix_step     = flow && is_pix;
    assign step         = flow || catchup;
    assign emit_now     = step && (emit_on_reg || (lead_cnt_reg == lag));
    assign col_last     = (vcol_reg == XW'(uw - WW'(1)));
    assign out_col_last = (out_col_reg == XW'(uw - WW'(1)));
    assign out_row_last = (out_row_reg == OROW_W'(uh - VROW_W'(1)));
    assign frame_done   = emit_now && out_col_last && out_row_last;
    assign cfg_write    = regs.valid && regs.ready;

    // Counter next state
    always_comb
    begin
        vcol_next     = vcol_reg;
        vrow_next     = vrow_reg;
        lead_cnt_next = lead_cnt_reg;
        emit_on_next  = emit_on_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        if (cfg_write || frame_done)
        begin
            vcol_next     = '0;
            vrow_next     = '0;
            lead_cnt_next = '0;
            emit_on_next  = 1'b0;
            out_col_next  = '0;
            out_row_next  = '0;
            wptr_next     = '0;
            rptr_next     = '0;
        end
        else if (step)
        begin
            if (col_last)
            begin
                vcol_next = '0;
                vrow_next = vrow_reg + VROW_W'(1);
            end
            else
            begin
                vcol_next = vcol_reg + XW'(1);
            end

            if (emit_now)
            begin
                emit_on_next = 1'b1;
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + XW'(1);
                end
                rptr_next = (rptr_reg == PAW'(PD - 1)) ? '0 : rptr_reg + PAW'(1);
            end
            else
            begin
                lead_cnt_next = lead_cnt_reg + LW'(1);
            end

            if (pix_step)
                wptr_next = (wptr_reg == PAW'(PD - 1)) ? '0 : wptr_reg + PAW'(1);
        end
    end

    // Column mask of the window taps; tap k lies k columns left of the newest
    always_comb
    begin
        cpr = SW'(out_col_reg) + SW'(RADIUS);
        for (int k = 0; k < WIN; k++)
            mask[k] = (cpr >= SW'(k)) && ((cpr - SW'(k)) < SW'(uw));
    end

    // Column distance to the last zero, and the horizontal window
    always_comb
    begin
        d_old = s1_fwd_reg ? fwd_val_reg : dist_q_reg;
        if (s1_zero_reg)
            d_new = '0;
        else if (s1_row0_reg || (d_old >= SAT))
            d_new = SAT;
        else
            d_new = d_old + DW'(1);
        vz_new   = (d_new != SAT);
        win      = {hist_reg, vz_new};
        zero_hit = |(win & s1_mask_reg);
    end

    assign push = s1_valid_reg && s1_emit_reg;
    assign pop  = results.valid && results.ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            vcol_reg     <= '0;
            vrow_reg     <= '0;
            lead_cnt_reg <= '0;
            emit_on_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (regs.index)
                    REG_IMAGE_WIDTH:  width_reg  <= regs.data;
                    REG_IMAGE_HEIGHT: height_reg <= regs.data;
                    default: ;
                endcase
            end
            vcol_reg     <= vcol_next;
            vrow_reg     <= vrow_next;
            lead_cnt_reg <= lead_cnt_next;
            emit_on_reg  <= emit_on_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            s1_valid_reg <= step;
            s1_emit_reg  <= emit_now;

            // queue pointers
            if (push)
                wr_idx_reg <= wr_idx_reg + FAW'(1);
            if (pop)
                rd_idx_reg <= rd_idx_reg + FAW'(1);
            cnt_reg <= cnt_reg + FCW'(push) - FCW'(pop);
        end
    end

    // Stage-one payload, window history and queue storage
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_zero_reg <= pix_step && (pixels.pixel_in == '0);
            s1_row0_reg <= (vrow_reg == '0);
            s1_col_reg  <= vcol_reg;
            s1_fwd_reg  <= s1_valid_reg && (s1_col_reg == vcol_reg);
            fwd_val_reg <= d_new;
            s1_mask_reg <= mask;
            s1_end_reg  <= frame_done;
        end
        if (s1_valid_reg)
            hist_reg <= {hist_reg[HW-2:0], vz_new};
        if (push)
        begin
            fifo_pix_reg[wr_idx_reg] <= zero_hit ? '0 : pix_q_reg;
            fifo_end_reg[wr_idx_reg] <= s1_end_reg;
        end
    end

    // Column distance RAM: read for the new item, write back from stage one
    always_ff @(posedge clk)
    begin
        if (step)
            dist_q_reg <= dist_mem[vcol_reg];
        if (s1_valid_reg)
            dist_mem[s1_col_reg] <= d_new;
    end

    // Centre pixel delay RAM
    always_ff @(posedge clk)
    begin
        if (emit_now)
            pix_q_reg <= pix_mem[rptr_reg];
        if (pix_step)
            pix_mem[wptr_reg] <= pixels.pixel_in;
    end

    // Handshakes
    assign pixels.ready      = ((cnt_reg + FCW'(s1_emit_reg && s1_valid_reg))
                                <= FCW'(FD - 1)) && !catchup;
    assign regs.ready        = 1'b1;
    assign results.valid     = (cnt_reg != '0);
    assign results.pixel_out = fifo_pix_reg[rd_idx_reg];
    assign results.frame_end = fifo_end_reg[rd_idx_reg];

endmodule

### tb/tb.sv
// Testbench for square_window_zero_spread: directed and random mask frames, with
// each eroded pixel checked against an in-bench predictor of the 15x15 erosion.
// Depends on sqws_pkg, sqws_pixel_if, sqws_result_if, sqws_cfg_if and the top level.

module tb;
    import sqws_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int RADIUS        = 7;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int FULL_FRAME    = 32'h7FFF_FFFF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    typedef struct packed {
        item_kind_t       kind;
        logic [PIX_W-1:0] value;
    } mask_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } eroded_pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    sqws_pixel_if  pixels_ch ();
    sqws_result_if results_ch ();
    sqws_cfg_if    regs_ch ();

    square_window_zero_spread #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels_ch),
        .results (results_ch),
        .regs    (regs_ch)
    );

    // Items waiting to be offered, eroded pixels waiting to come out
    mask_item_t    mask_feed [$];
    eroded_pixel_t eroded_due [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int feed_count     = 0;
    int quiet_cycles   = 0;

    // Erosion predictor state: registers, raster position, copy of the frame
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_in;
    int unsigned      row_in;
    int unsigned      out_count;
    byte unsigned     frame_store [MAX_WIDTH*MAX_HEIGHT];

    always #5 clk = ~clk;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void clear_position();
        col_in    = 0;
        row_in    = 0;
        out_count = 0;
    endfunction

    // Next output pixel: zero if its clamped window holds a zero in the input frame
    function automatic eroded_pixel_t erode_next(input int unsigned w, input int unsigned h);
        eroded_pixel_t res;
        int unsigned   o;
        int            r, c, y0, y1, x0, x1, y, x;
        bit            zero_hit;
        o  = out_count;
        r  = o / w;
        c  = o % w;
        y0 = (r > RADIUS) ? r - RADIUS : 0;
        x0 = (c > RADIUS) ? c - RADIUS : 0;
        y1 = r + RADIUS;
        x1 = c + RADIUS;
        if (y1 > int'(h) - 1) y1 = int'(h) - 1;
        if (x1 > int'(w) - 1) x1 = int'(w) - 1;
        zero_hit = 1'b0;
        for (y = y0; y <= y1; y++)
            for (x = x0; x <= x1; x++)
                if (frame_store[y*MAX_WIDTH + x] == 0) zero_hit = 1'b1;
        res.value = zero_hit ? '0 : frame_store[r*MAX_WIDTH + c];
        res.last  = (o == w*h - 1);
        out_count = o + 1;
        if (res.last) clear_position();
        return res;
    endfunction

    // Apply one accepted item; queue the eroded pixel it releases, if any
    function automatic void erode_accept(input mask_item_t it);
        int unsigned w, h, lag, p;
        w   = active_width();
        h   = active_height();
        lag = RADIUS*w + RADIUS;
        if (col_in >= w || row_in > h) clear_position();
        if (it.kind == KIND_PIXEL)
        begin
            // pixels past frame end are dropped while outputs are pending
            if (row_in >= h) return;
            p = row_in*w + col_in;
            frame_store[row_in*MAX_WIDTH + col_in] = it.value;
            col_in++;
            if (col_in == w)
            begin
                col_in = 0;
                row_in++;
            end
            if (p >= lag) eroded_due.insert(eroded_due.size(), erode_next(w, h));
        end
        else
        begin
            // flush ticks do nothing until the whole frame is in
            if (row_in < h) return;
            if (out_count >= w*h)
            begin
                clear_position();
                return;
            end
            eroded_due.insert(eroded_due.size(), erode_next(w, h));
        end
    endfunction

    // Pixel channel driver: holds an item until its transfer, idles at random
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        mask_item_t nxt;
        logic       busy;
        if (!rst_n)
        begin
            pixels_ch.valid    <= 1'b0;
            pixels_ch.kind     <= KIND_PIXEL;
            pixels_ch.pixel_in <= '0;
        end
        else
        begin
            busy = pixels_ch.valid;
            if (pixels_ch.valid && pixels_ch.ready)
            begin
                nxt.kind  = pixels_ch.kind;
                nxt.value = pixels_ch.pixel_in;
                erode_accept(nxt);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (mask_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = mask_feed.pop_front();
                    pixels_ch.valid    <= 1'b1;
                    pixels_ch.kind     <= nxt.kind;
                    pixels_ch.pixel_in <= nxt.value;
                end
                else
                begin
                    pixels_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls, or a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            results_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            results_ch.ready <= 1'b0;
        end
        else
        begin
            results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor: every transfer against the oldest predicted pixel
    always @(posedge clk)
    begin : check_results
        eroded_pixel_t due;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (eroded_due.size() == 0)
            begin
                $display("%0t: result with none expected: pixel_out %0d frame_end %0b",
                         $time, results_ch.pixel_out, results_ch.frame_end);
                mismatches++;
            end
            else
            begin
                due = eroded_due.pop_front();
                if (results_ch.pixel_out !== due.value)
                begin
                    $display("%0t: pixel_out expected %0d, got %0d",
                             $time, due.value, results_ch.pixel_out);
                    mismatches++;
                end
                if (results_ch.frame_end !== due.last)
                begin
                    $display("%0t: frame_end expected %0b, got %0b",
                             $time, due.last, results_ch.frame_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((pixels_ch.valid && pixels_ch.ready)
                 || (results_ch.valid && results_ch.ready)
                 || (regs_ch.valid && regs_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default:
            begin
                send_idle_pct  = 10;
                recv_stall_pct = 10;
            end
        endcase
    endtask

    // Wait for every item sent and every eroded pixel out, then let the pipe settle
    task automatic wait_drained();
        do @(negedge clk);
        while (mask_feed.size() != 0 || pixels_ch.valid || eroded_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; the predictor follows at the transfer
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        regs_ch.valid <= 1'b1;
        regs_ch.index <= idx;
        regs_ch.data  <= val;
        do @(posedge clk); while (regs_ch.ready !== 1'b1);
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        clear_position();
        regs_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_item(input item_kind_t k, input logic [PIX_W-1:0] v);
        mask_item_t it;
        it.kind  = k;
        it.value = v;
        mask_feed.insert(mask_feed.size(), it);
    endtask

    // Zero with the given chance per thousand, else a random non-zero value
    function automatic logic [PIX_W-1:0] mask_value(input int zero_pm);
        if ($urandom_range(999) < zero_pm) return '0;
        return 8'($urandom_range(1, 255));
    endfunction

    // One frame at the current size: pixels, then the flush ticks that drain it.
    // cut_at truncates the frame (no flush), pause_at drains mid-frame, noisy adds
    // flush ticks among the pixels and pixels among the flush ticks.
    task automatic queue_frame(input int zero_pm, input bit noisy,
                               input int unsigned cut_at, input int unsigned pause_at);
        int unsigned w, h, n_pix, n_flush, i;
        w       = active_width();
        h       = active_height();
        n_pix   = w * h;
        n_flush = (n_pix < RADIUS*w + RADIUS) ? n_pix : RADIUS*w + RADIUS;
        if (cut_at < n_pix)
        begin
            n_pix   = cut_at;
            n_flush = 0;
        end
        for (i = 0; i < n_pix; i++)
        begin
            if (pause_at != 0 && i == pause_at) wait_drained();
            if (noisy && $urandom_range(19) == 0) push_item(KIND_FLUSH, 8'($urandom));
            push_item(KIND_PIXEL, mask_value(zero_pm));
            feed_count++;
        end
        for (i = 0; i < n_flush; i++)
        begin
            if (noisy && $urandom_range(19) == 0) push_item(KIND_PIXEL, mask_value(zero_pm));
            push_item(KIND_FLUSH, 8'($urandom));
            feed_count++;
        end
    endtask

    initial
    begin : stimulus
        logic [PIX_W-1:0] opening [8] = '{8'd255, 8'd1, 8'd128, 8'd127,
                                          8'd254, 8'd2, 8'd85, 8'd170};
        int unsigned      w, h, shape, nframes, f, cut, pause;
        int               zero_pm, phase;

        rst_n         <= 1'b0;
        regs_ch.valid <= 1'b0;
        regs_ch.index <= REG_IMAGE_WIDTH;
        regs_ch.data  <= '0;
        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        clear_position();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 2x4 frame, all non-zero: a flush before frame end and a pixel among
        // the flush ticks are ignored, and so is a flush after completion
        write_reg(REG_IMAGE_WIDTH, 11'd2);
        write_reg(REG_IMAGE_HEIGHT, 11'd4);
        for (int i = 0; i < 8; i++)
        begin
            if (i == 4) push_item(KIND_FLUSH, 8'h00);
            push_item(KIND_PIXEL, opening[i]);
        end
        for (int i = 0; i < 8; i++)
        begin
            if (i == 3) push_item(KIND_PIXEL, 8'h00);
            push_item(KIND_FLUSH, 8'hFF);
        end
        push_item(KIND_FLUSH, 8'h5A);
        wait_drained();

        // Zero registers saturate to a 1x1 frame, flushed out; a new frame follows
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        push_item(KIND_PIXEL, 8'h00);
        push_item(KIND_FLUSH, 8'h00);
        push_item(KIND_PIXEL, 8'd77);
        push_item(KIND_FLUSH, 8'h00);
        wait_drained();

        // Receiver holds off while the sender keeps going: the block backs up
        set_idling(IDLE_NONE);
        write_reg(REG_IMAGE_WIDTH, 11'd4);
        write_reg(REG_IMAGE_HEIGHT, 11'd16);
        hold_requests++;
        queue_frame(10, 1'b0, FULL_FRAME, 0);
        wait_drained();

        // Random frames, mostly small, under rotating idling
        phase = 0;
        while (feed_count < RANDOM_ITEMS)
        begin
            set_idling(idling_t'(phase % 4));
            if ($urandom_range(3) == 0)
            begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 6);
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
            end
            write_reg(REG_IMAGE_WIDTH, w[CFG_W-1:0]);
            write_reg(REG_IMAGE_HEIGHT, h[CFG_W-1:0]);
            case ($urandom_range(4))
                0:       zero_pm = 0;
                1:       zero_pm = 3;
                2:       zero_pm = 15;
                3:       zero_pm = 60;
                default: zero_pm = 400;
            endcase
            shape   = $urandom_range(9);
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
            begin
                // shape 8 leaves the last frame unfinished, the next write drops it
                cut   = (shape == 8 && f == nframes - 1) ? $urandom_range(0, w*h - 1)
                                                         : FULL_FRAME;
                pause = (shape == 9 && w*h > 1) ? $urandom_range(1, w*h - 1) : 0;
                queue_frame(zero_pm, shape == 6 || shape == 7, cut, pause);
            end
            wait_drained();
            phase++;
        end

        // Register extremes: widest row and tallest column (both saturated),
        // as partial frames that the next write drops
        set_idling(IDLE_BOTH);
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, 11'd1);
        queue_frame(40, 1'b0, 60, 0);
        wait_drained();

        set_idling(IDLE_SENDER);
        write_reg(REG_IMAGE_WIDTH, 11'd1);
        write_reg(REG_IMAGE_HEIGHT, '1);
        queue_frame(40, 1'b0, 200, 0);
        wait_drained();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/sqws_pkg.sv
rtl/sqws_pixel_if.sv
rtl/sqws_result_if.sv
rtl/sqws_cfg_if.sv
rtl/square_window_zero_spread.sv
tb/tb.sv
